// ----- sv/sha_pkg.sv -----
package sha_pkg;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // padding
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        has_byte;
    logic        end_of_message;
    logic [7:0]  data_byte;
    logic [63:0] bit_len;
  } cmd_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- sv/sha_front.sv -----
module sha_front import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  logic [60:0] msg_bytes;
  logic [60:0] len_with_item;
  logic        take;

  assign item_ready    = cmd_ready;
  assign take          = item_valid && item_ready;
  assign len_with_item = msg_bytes + 61'(item.has_byte);

  // idle items are taken and dropped here
  assign cmd_valid          = item_valid && (item.has_byte || item.end_of_message);
  assign cmd.has_byte       = item.has_byte;
  assign cmd.end_of_message = item.end_of_message;
  assign cmd.data_byte      = item.data_byte;
  assign cmd.bit_len        = {len_with_item, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_bytes <= '0;
    end else if (take) begin
      if (item.end_of_message) begin
        msg_bytes <= '0;
      end else begin
        msg_bytes <= len_with_item;
      end
    end
  end

endmodule

// ----- sv/sha_queue.sv -----
module sha_queue import sha_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/sha_back.sv -----
module sha_back import sha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    digest_valid,
  input  logic    digest_ready,
  output digest_t digest
);

  localparam logic [2:0] ST_FILL  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]   state;
  logic [5:0]   fill;
  logic [5:0]   round;
  logic [2:0]   idx;
  logic         padding;
  logic         mark_sent;
  logic         len_phase;
  logic         finish;
  logic [63:0]  len_bits;
  logic [31:0]  hash [8];
  logic [31:0]  vars [8];
  logic [511:0] block;

  logic         push_en;
  logic [7:0]   push_byte;
  logic [7:0]   pad_byte;
  logic [5:0]   len_shift;
  logic [31:0]  w_cur;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  // block words: word k sits at bits 511-32k, word 0 is the oldest
  assign w_cur = block[511 -: 32];
  assign w_new = small_sigma1(block[63 -: 32]) + block[223 -: 32]
               + small_sigma0(block[479 -: 32]) + w_cur;

  assign t1 = vars[7] + big_sigma1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
            + ROUND_K[round] + w_cur;
  assign t2 = big_sigma0(vars[0])
            + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));

  assign len_shift = LEN_START - {fill[2:0], 3'b000};

  always_comb begin
    if (!mark_sent) begin
      pad_byte = PAD_MARK;
    end else if (len_phase || fill == LEN_START) begin
      pad_byte = 8'(len_bits >> len_shift);
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign cmd_ready = state == ST_FILL;

  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    case (state)
      ST_FILL: begin
        push_en   = cmd_valid && cmd.has_byte;
        push_byte = cmd.data_byte;
      end
      ST_PAD: begin
        push_en   = 1'b1;
        push_byte = pad_byte;
      end
      default: begin
        push_en   = 1'b0;
        push_byte = 8'h00;
      end
    endcase
  end

  assign digest_valid       = state == ST_EMIT;
  assign digest.digest_word = hash[idx];
  assign digest.word_index  = idx;
  assign digest.final_word  = idx == LAST_WORD;

  // control and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill      <= '0;
      round     <= '0;
      idx       <= '0;
      padding   <= 1'b0;
      mark_sent <= 1'b0;
      len_phase <= 1'b0;
      finish    <= 1'b0;
      for (int j = 0; j < 8; j++) begin
        hash[j] <= INIT_H[j];
      end
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      case (state)
        ST_FILL: begin
          if (cmd_valid) begin
            if (cmd.end_of_message) begin
              padding  <= 1'b1;
              len_bits <= cmd.bit_len;
            end
            if (cmd.has_byte && fill == LAST_BYTE) begin
              state <= ST_ROUND;
            end else if (cmd.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!mark_sent) begin
            mark_sent <= 1'b1;
          end else if (fill == LEN_START) begin
            len_phase <= 1'b1;
          end
          if (len_phase && fill == LAST_BYTE) begin
            finish <= 1'b1;
          end
          if (fill == LAST_BYTE) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == LAST_ROUND) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int j = 0; j < 8; j++) begin
            hash[j] <= hash[j] + vars[j];
          end
          if (finish) begin
            state <= ST_EMIT;
          end else if (padding) begin
            state <= ST_PAD;
          end else begin
            state <= ST_FILL;
          end
        end
        ST_EMIT: begin
          if (digest_ready) begin
            idx <= idx + 3'd1;
            if (idx == LAST_WORD) begin
              for (int j = 0; j < 8; j++) begin
                hash[j] <= INIT_H[j];
              end
              padding   <= 1'b0;
              mark_sent <= 1'b0;
              len_phase <= 1'b0;
              finish    <= 1'b0;
              state     <= ST_FILL;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  // block shift line doubles as the rolling message schedule
  always_ff @(posedge clk) begin
    if (push_en) begin
      block <= {block[503:0], push_byte};
    end
    if (push_en && fill == LAST_BYTE) begin
      for (int j = 0; j < 8; j++) begin
        vars[j] <= hash[j];
      end
    end
    if (state == ST_ROUND) begin
      block   <= {block[479:0], w_new};
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

// ----- sv/sha256_stream_hasher.sv -----
// byte flow: a byte request is written into the queue at acceptance and absorbed by the core from the queue head
// throughput: one byte per cycle while filling and the queue holds bytes; 64 rounds plus an add step per 64-byte block
// sustained rate set by the single-round compression loop, which takes no new bytes while a block compresses
// end of message: padding bytes go in one per cycle, then one or two block compressions, then 8 digest words
// reset: synchronous, loads the initial hash vector and empties the queue, no clearing pass
module sha256_stream_hasher import sha_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    digest_valid,
  input  logic    digest_ready,
  output digest_t digest
);

  // front to queue
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;

  // queue to back
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  // front: drops idle requests, counts message length, tags the end request with bit length
  sha_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd        (fq_cmd)
  );

  // short queue so the front keeps taking bytes, up to the queue depth, while the back compresses or emits
  sha_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // back: block buffer, padding, 64-round compression and digest output
  sha_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule

// ----- sv/sha_checker.sv -----
module sha_checker import sha_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    digest_valid,
  input logic    digest_ready,
  input digest_t digest
);

  // stalled digest word holds
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest changed while stalled");

  // words of a digest come back to back in index order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.final_word |=>
      digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)
    else $error("digest word index out of order");

  a_final_flag: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> digest.final_word == (digest.word_index == LAST_WORD))
    else $error("final flag does not match word index");

  // a new digest needs a full compression first
  a_gap_after_final: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest.final_word |=> !digest_valid)
    else $error("digest restarted right after final word");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !digest_valid)
    else $error("digest valid right after reset");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest       (digest)
);
